// ===== rtl/ears_pkg.sv =====
// Shared types, constants and helper functions for the echo and SYN-ACK responder.
// Used by every module of the block except ears_ram; depends on nothing else.
package ears_pkg;

	localparam int FRAME_BYTES = 2048;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int CSUM_W      = 26;
	localparam int SLOT_W      = 6;

	localparam logic [CNT_W-1:0]  MIN_FRAME   = CNT_W'(34);
	localparam logic [CNT_W-1:0]  ETH_HDR     = CNT_W'(14);
	localparam logic [CNT_W-1:0]  TCP_HDR     = CNT_W'(20);
	localparam logic [15:0]       ETYPE_IPV4  = 16'h0800;
	localparam logic [7:0]        PROTO_ICMP  = 8'd1;
	localparam logic [7:0]        PROTO_TCP   = 8'd6;
	localparam logic [7:0]        ICMP_ECHO   = 8'd8;
	localparam logic [7:0]        TCP_OFF5    = 8'h50;
	localparam logic [7:0]        TCP_SYN_ACK = 8'h12;
	localparam logic [15:0]       TCP_WINDOW  = 16'd64240;
	localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(43);

	localparam logic CFG_RESPONDER_IP = 1'b0;
	localparam logic CFG_SYN_ACK_SEQ  = 1'b1;

	typedef enum logic [2:0] {
		KIND_DROP   = 3'd0,
		KIND_ECHO   = 3'd1,
		KIND_SYNACK = 3'd2,
		KIND_BYTE   = 3'd3,
		KIND_NONE   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		OP_PUSH      = 2'd0,
		OP_PUSH_LAST = 2'd1,
		OP_PULL      = 2'd2
	} op_code_t;

	typedef struct packed {
		op_code_t    code;
		logic [7:0]  data;
	} op_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data;
		logic              last;
		logic [CNT_W-1:0]  len;
	} res_item_t;

	function automatic logic [15:0] csum_fold(input logic [CSUM_W-1:0] s);
		logic [16:0] s1;
		logic [16:0] s2;
		s1 = {1'b0, s[15:0]} + 17'(s[CSUM_W-1:16]);
		s2 = {1'b0, s1[15:0]} + 17'(s1[16]);
		return ~s2[15:0];
	endfunction

	function automatic logic [7:0] byte_of(input logic [31:0] v, input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0: r = v[31:24];
			2'd1: r = v[23:16];
			2'd2: r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/echo_and_syn_ack_responder_core.sv =====
// Top level of the ICMP echo and TCP SYN-ACK responder: configuration registers,
// front queue, engine and result queue. Depends on ears_pkg and all ears_* modules.
//
// Requests enter through a two-entry queue and results leave through another. A pushed frame
// byte is written to the frame store as it is taken, unless the store is full. The last byte
// of a frame is followed by the checksum-completion states CK1 to CK4 and, for an accepted
// frame, a pass that rewrites the header in the frame store one byte per cycle through its
// single write port; the result is then handed on, and a dropped frame is handed on after CK4.
// A pull of a reply byte goes through the registered read of the frame store before it is
// handed on, and a pull with nothing pending is handed on without a read. A full result queue
// stalls the hand-on. The IP and ICMP checksums accumulate while bytes are loaded, so frame
// length does not add to the end-of-frame work.
module echo_and_syn_ack_responder_core import ears_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  result_kind,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [11:0] reply_length,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] resp_ip_q;
	logic [31:0] seq_cfg_q;
	logic        op_valid;
	logic        op_ready;
	op_item_t    op;
	logic        res_valid;
	logic        res_ready;
	res_item_t   res;
	res_item_t   head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_ip_q <= '0;
			seq_cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RESPONDER_IP: resp_ip_q <= cfg_data;
				CFG_SYN_ACK_SEQ:  seq_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ears_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	ears_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.resp_ip   (resp_ip_q),
		.seq_cfg   (seq_cfg_q)
	);

	ears_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign result_kind  = head.kind;
	assign out_byte     = head.data;
	assign out_last     = head.last;
	assign reply_length = head.len;

	a_byte_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind == KIND_BYTE) |-> reply_length != 12'd0)
		else $error("reply byte with zero reply length");

	a_drop_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result_kind == KIND_DROP || result_kind == KIND_NONE))
		|-> reply_length == 12'd0)
		else $error("dropped or empty result carries a length");

	a_last_only_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_last) |-> result_kind == KIND_BYTE)
		else $error("last flag on a result that is not a reply byte");

endmodule

// ===== rtl/ears_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module ears_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ears_front.sv =====
// Front end: classifies each request and holds it in a two-entry queue.
// Depends on ears_pkg.
module ears_front import ears_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  logic     req_type,
	input  logic [7:0] in_byte,
	input  logic     in_last,
	output logic     op_valid,
	input  logic     op_ready,
	output op_item_t op
);

	op_item_t   slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;
	op_item_t   item;

	always_comb begin
		item.data = in_byte;
		if (req_type) begin
			item.code = OP_PULL;
		end else if (in_last) begin
			item.code = OP_PUSH_LAST;
		end else begin
			item.code = OP_PUSH;
		end
	end

	assign full     = (cnt_q == 2'd2);
	assign op_valid = (cnt_q != 2'd0);
	assign op       = slot_q[rp_q];
	assign wr_en    = push && !full;
	assign rd_en    = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

// ===== rtl/ears_resq.sv =====
// Result queue: two entries between the engine and the result ports.
// Depends on ears_pkg.
module ears_resq import ears_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	output logic      res_ready,
	input  res_item_t res,
	output logic      empty,
	input  logic      pop,
	output res_item_t head
);

	res_item_t  slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign res_ready = (cnt_q != 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign head      = slot_q[rp_q];
	assign wr_en     = res_valid && res_ready;
	assign rd_en     = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

// ===== rtl/ears_engine.sv =====
// Back end: frame store, header capture with running checksums, frame judging,
// the in-place header rewrite and the reply read-out. Depends on ears_pkg and ears_ram.
module ears_engine import ears_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_ready,
	input  op_item_t    op,
	output logic        res_valid,
	input  logic        res_ready,
	output res_item_t   res,
	input  logic [31:0] resp_ip,
	input  logic [31:0] seq_cfg
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PULL = 8'b0000_0010,
		ST_CK1  = 8'b0000_0100,
		ST_CK2  = 8'b0000_1000,
		ST_CK3  = 8'b0001_0000,
		ST_CK4  = 8'b0010_0000,
		ST_WR   = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  wc_q;
	logic              ov_q;
	logic              pending_q;
	logic [CNT_W-1:0]  rpos_q;
	logic [CNT_W-1:0]  rsize_q;
	logic [7:0]        mac_q [12];
	logic [15:0]       et_q;
	logic [3:0]        ihl_q;
	logic [15:0]       tot_q;
	logic [7:0]        proto_q;
	logic [31:0]       sa_q;
	logic [31:0]       da_q;
	logic [7:0]        l4_q [8];
	logic [7:0]        flags_q;
	logic [CSUM_W-1:0] ip_acc_q;
	logic [CSUM_W-1:0] icmp_acc_q;
	logic [CSUM_W-1:0] tcp_acc_q;
	logic [31:0]       ack_q;
	kind_t             kind_q;
	logic [CNT_W-1:0]  len_q;
	logic [15:0]       tot_wr_q;
	logic [15:0]       ipcs_q;
	logic [15:0]       l4cs_q;
	logic [SLOT_W-1:0] slot_q;
	res_item_t         res_q;

	logic              take;
	logic              is_push;
	logic              store_ok;
	logic [CNT_W-1:0]  ihl4;
	logic [CNT_W-1:0]  t_pos;
	logic [CNT_W-1:0]  off;
	logic              l4_zone;
	logic              ip_in;
	logic              icmp_in;
	logic [15:0]       word;
	logic [16:0]       tot_end;
	logic              hdr_bad;
	logic              icmp_ok;
	logic              tcp_ok;
	logic [15:0]       new_tot;
	logic [31:0]       seq_in;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;
	logic              slot_en;
	logic [CNT_W-1:0]  slot_addr;
	logic [7:0]        slot_data;
	logic [4:0]        sub;
	logic [SLOT_W-1:0] rel;

	assign take     = (state_q == ST_IDLE) && op_valid;
	assign op_ready = (state_q == ST_IDLE);
	assign is_push  = (op.code != OP_PULL);
	assign store_ok = (wc_q < CNT_W'(FRAME_BYTES));
	assign ihl4     = {{(CNT_W-6){1'b0}}, ihl_q, 2'b00};
	assign t_pos    = ETH_HDR + ihl4;
	assign off      = wc_q - t_pos;
	assign word     = wc_q[0] ? {8'h00, op.data} : {op.data, 8'h00};
	assign tot_end  = 17'(ETH_HDR) + 17'(tot_q);
	assign seq_in   = {l4_q[4], l4_q[5], l4_q[6], l4_q[7]};

	always_comb begin
		l4_zone = (wc_q >= MIN_FRAME) && (wc_q >= t_pos);
		ip_in   = (wc_q == ETH_HDR) || ((wc_q > ETH_HDR) && (wc_q < t_pos));
		if (wc_q == CNT_W'(16) || wc_q == CNT_W'(17)
				|| (wc_q >= CNT_W'(24) && wc_q <= CNT_W'(33))) begin
			ip_in = 1'b0;
		end
		icmp_in = l4_zone && (17'(wc_q) < tot_end) && (off != CNT_W'(0))
			&& (off != CNT_W'(2)) && (off != CNT_W'(3));
	end

	always_comb begin
		hdr_bad = ov_q || (wc_q < MIN_FRAME) || (et_q != ETYPE_IPV4)
			|| (ihl_q < 4'd5) || (t_pos > wc_q);
		icmp_ok = !hdr_bad && (proto_q == PROTO_ICMP)
			&& (17'(tot_q) >= 17'(ihl4) + 17'd8) && (tot_end <= 17'(wc_q))
			&& (l4_q[0] == ICMP_ECHO) && (da_q == resp_ip);
		tcp_ok = !hdr_bad && (proto_q == PROTO_TCP) && (t_pos + TCP_HDR <= wc_q)
			&& (da_q == resp_ip) && flags_q[1];
		new_tot = tcp_ok ? (16'(ihl4) + 16'(TCP_HDR)) : tot_q;
	end

	always_comb begin
		slot_en   = 1'b1;
		slot_addr = CNT_W'(slot_q);
		slot_data = 8'h00;
		rel       = slot_q - SLOT_W'(24);
		sub       = rel[4:0];
		if (slot_q < SLOT_W'(6)) begin
			slot_data = mac_q[slot_q[3:0] + 4'd6];
		end else if (slot_q < SLOT_W'(12)) begin
			slot_data = mac_q[slot_q[3:0] - 4'd6];
		end else if (slot_q < SLOT_W'(14)) begin
			slot_en   = (kind_q == KIND_SYNACK);
			slot_addr = CNT_W'(slot_q) + CNT_W'(4);
			slot_data = slot_q[0] ? tot_wr_q[7:0] : tot_wr_q[15:8];
		end else if (slot_q < SLOT_W'(16)) begin
			slot_addr = CNT_W'(slot_q) + CNT_W'(10);
			slot_data = slot_q[0] ? ipcs_q[7:0] : ipcs_q[15:8];
		end else if (slot_q < SLOT_W'(20)) begin
			slot_addr = CNT_W'(slot_q) + CNT_W'(10);
			slot_data = byte_of(resp_ip, slot_q[1:0]);
		end else if (slot_q < SLOT_W'(24)) begin
			slot_addr = CNT_W'(slot_q) + CNT_W'(10);
			slot_data = byte_of(sa_q, slot_q[1:0]);
		end else begin
			slot_addr = t_pos + CNT_W'(sub);
			if (kind_q == KIND_SYNACK) begin
				case (sub)
					5'd0, 5'd1: slot_data = l4_q[3'(sub) + 3'd2];
					5'd2, 5'd3: slot_data = l4_q[3'(sub) - 3'd2];
					5'd4, 5'd5, 5'd6, 5'd7: slot_data = byte_of(seq_cfg, sub[1:0]);
					5'd8, 5'd9, 5'd10, 5'd11: slot_data = byte_of(ack_q, sub[1:0]);
					5'd12: slot_data = TCP_OFF5;
					5'd13: slot_data = TCP_SYN_ACK;
					5'd14: slot_data = TCP_WINDOW[15:8];
					5'd15: slot_data = TCP_WINDOW[7:0];
					5'd16: slot_data = l4cs_q[15:8];
					5'd17: slot_data = l4cs_q[7:0];
					default: slot_data = 8'h00;
				endcase
			end else begin
				slot_en = (sub == 5'd0) || (sub == 5'd2) || (sub == 5'd3);
				case (sub)
					5'd2: slot_data = l4cs_q[15:8];
					5'd3: slot_data = l4cs_q[7:0];
					default: slot_data = 8'h00;
				endcase
			end
		end
	end

	always_comb begin
		if (state_q == ST_WR) begin
			ram_we    = slot_en;
			ram_waddr = slot_addr[ADDR_W-1:0];
			ram_wdata = slot_data;
		end else begin
			ram_we    = take && is_push && store_ok;
			ram_waddr = wc_q[ADDR_W-1:0];
			ram_wdata = op.data;
		end
	end

	ears_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rpos_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (take && is_push && store_ok) begin
			if (wc_q < CNT_W'(12)) begin
				mac_q[wc_q[3:0]] <= op.data;
			end
			case (wc_q)
				CNT_W'(12): et_q[15:8]   <= op.data;
				CNT_W'(13): et_q[7:0]    <= op.data;
				CNT_W'(14): ihl_q        <= op.data[3:0];
				CNT_W'(16): tot_q[15:8]  <= op.data;
				CNT_W'(17): tot_q[7:0]   <= op.data;
				CNT_W'(23): proto_q      <= op.data;
				CNT_W'(26): sa_q[31:24]  <= op.data;
				CNT_W'(27): sa_q[23:16]  <= op.data;
				CNT_W'(28): sa_q[15:8]   <= op.data;
				CNT_W'(29): sa_q[7:0]    <= op.data;
				CNT_W'(30): da_q[31:24]  <= op.data;
				CNT_W'(31): da_q[23:16]  <= op.data;
				CNT_W'(32): da_q[15:8]   <= op.data;
				CNT_W'(33): da_q[7:0]    <= op.data;
				default: ;
			endcase
			if (l4_zone && off < CNT_W'(8)) begin
				l4_q[off[2:0]] <= op.data;
			end
			if (l4_zone && off == CNT_W'(13)) begin
				flags_q <= op.data;
			end
		end
		if (state_q == ST_CK1) begin
			kind_q   <= icmp_ok ? KIND_ECHO : (tcp_ok ? KIND_SYNACK : KIND_DROP);
			len_q    <= icmp_ok ? tot_end[CNT_W-1:0] : (tcp_ok ? t_pos + TCP_HDR : '0);
			tot_wr_q <= new_tot;
			ack_q    <= seq_in + 32'd1;
		end
		if (state_q == ST_CK4) begin
			ipcs_q <= csum_fold(ip_acc_q);
			l4cs_q <= (kind_q == KIND_SYNACK) ? csum_fold(tcp_acc_q) : csum_fold(icmp_acc_q);
		end
		if (state_q == ST_CK1) begin
			tcp_acc_q <= CSUM_W'(resp_ip[31:16]) + CSUM_W'(resp_ip[15:0])
				+ CSUM_W'(PROTO_TCP) + CSUM_W'(TCP_HDR);
		end else if (state_q == ST_CK2) begin
			tcp_acc_q <= tcp_acc_q + CSUM_W'(sa_q[31:16]) + CSUM_W'(sa_q[15:0])
				+ CSUM_W'({l4_q[0], l4_q[1]}) + CSUM_W'({l4_q[2], l4_q[3]});
		end else if (state_q == ST_CK3) begin
			tcp_acc_q <= tcp_acc_q + CSUM_W'(seq_cfg[31:16]) + CSUM_W'(seq_cfg[15:0])
				+ CSUM_W'(ack_q[31:16]) + CSUM_W'(ack_q[15:0])
				+ CSUM_W'({TCP_OFF5, TCP_SYN_ACK}) + CSUM_W'(TCP_WINDOW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wc_q       <= '0;
			ov_q       <= 1'b0;
			pending_q  <= 1'b0;
			rpos_q     <= '0;
			rsize_q    <= '0;
			ip_acc_q   <= '0;
			icmp_acc_q <= '0;
			slot_q     <= '0;
			res_q      <= '{kind: KIND_NONE, data: 8'h00, last: 1'b0, len: '0};
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take && is_push) begin
						pending_q <= 1'b0;
						if (store_ok) begin
							wc_q <= wc_q + CNT_W'(1);
							if (ip_in) begin
								ip_acc_q <= ip_acc_q + CSUM_W'(word);
							end
							if (icmp_in) begin
								icmp_acc_q <= icmp_acc_q + CSUM_W'(word);
							end
						end else begin
							ov_q <= 1'b1;
						end
						if (op.code == OP_PUSH_LAST) begin
							state_q <= ST_CK1;
						end
					end else if (take) begin
						if (!pending_q || rpos_q >= rsize_q) begin
							pending_q <= 1'b0;
							res_q     <= '{kind: KIND_NONE, data: 8'h00, last: 1'b0, len: '0};
							state_q   <= ST_EMIT;
						end else begin
							state_q <= ST_PULL;
						end
					end
				end
				ST_PULL: begin
					res_q <= '{kind: KIND_BYTE, data: ram_rdata,
						last: (rpos_q + CNT_W'(1) == rsize_q), len: rsize_q};
					rpos_q <= rpos_q + CNT_W'(1);
					if (rpos_q + CNT_W'(1) >= rsize_q) begin
						pending_q <= 1'b0;
					end
					state_q <= ST_EMIT;
				end
				ST_CK1: begin
					ip_acc_q <= ip_acc_q + CSUM_W'(new_tot) + CSUM_W'(resp_ip[31:16])
						+ CSUM_W'(resp_ip[15:0]);
					state_q <= ST_CK2;
				end
				ST_CK2: begin
					ip_acc_q <= ip_acc_q + CSUM_W'(sa_q[31:16]) + CSUM_W'(sa_q[15:0]);
					state_q  <= ST_CK3;
				end
				ST_CK3: begin
					state_q <= ST_CK4;
				end
				ST_CK4: begin
					wc_q       <= '0;
					ov_q       <= 1'b0;
					ip_acc_q   <= '0;
					icmp_acc_q <= '0;
					if (kind_q == KIND_DROP) begin
						res_q   <= '{kind: KIND_DROP, data: 8'h00, last: 1'b0, len: '0};
						state_q <= ST_EMIT;
					end else begin
						slot_q  <= '0;
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					slot_q <= slot_q + SLOT_W'(1);
					if (slot_q == SLOT_LAST) begin
						res_q     <= '{kind: kind_q, data: 8'h00, last: 1'b0, len: len_q};
						pending_q <= 1'b1;
						rsize_q   <= len_q;
						rpos_q    <= '0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = (state_q == ST_EMIT);
	assign res       = res_q;

endmodule
